// ----- rtl/core/mbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multicolor bitmap decode package
// Shared types, image layout constants and the fixed 16-color palette.
// ----------------------------------------------------------------------------
package mbd_pkg;

  // Image layout, counted in stored image bytes.
  localparam int unsigned BitmapBytes = 8000;
  localparam int unsigned ScreenBytes = 1000;
  localparam int unsigned ColorBytes  = 1000;

  localparam int unsigned CountW   = 14;
  localparam int unsigned BmAddrW  = $clog2(BitmapBytes);
  localparam int unsigned CellAddrW = $clog2(ScreenBytes);

  localparam logic [CountW-1:0] BitmapEnd  = CountW'(BitmapBytes);
  localparam logic [CountW-1:0] ScreenEnd  = CountW'(BitmapBytes + ScreenBytes);
  localparam logic [CountW-1:0] ColorEnd   = CountW'(BitmapBytes + ScreenBytes + ColorBytes);
  localparam logic [CountW-1:0] ImageBytes = CountW'(BitmapBytes + ScreenBytes + ColorBytes + 1);

  // Load address header that is dropped when it opens the stream.
  localparam logic [7:0] HdrFirst  = 8'h00;
  localparam logic [7:0] HdrSecond = 8'h60;

  // Coordinate limits.
  localparam logic [7:0] LastColumn = 8'd159;
  localparam logic [7:0] LastRow    = 8'd199;

  // Request kinds.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqPixel = 1'b1;

  // Pixel codes of a cell.
  localparam logic [1:0] CodeBackground = 2'd0;
  localparam logic [1:0] CodeScreenHigh = 2'd1;
  localparam logic [1:0] CodeScreenLow  = 2'd2;
  localparam logic [1:0] CodeColor      = 2'd3;

  // Palette entries as {red, green, blue}.
  localparam logic [23:0] Palette [16] = '{
    24'h000000, 24'hFFFFFF, 24'hAA1111, 24'h0CCCCC,
    24'hDD33DD, 24'h00BB00, 24'h0000CC, 24'hFFFF8C,
    24'hCC7722, 24'h884400, 24'hFF9988, 24'h5C5C5C,
    24'hAAAAAA, 24'h8CFFB2, 24'h2794FF, 24'hC4C4C4
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] load_byte;
    logic [7:0] column;
    logic [7:0] row;
  } mbd_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       not_loaded;
  } mbd_out_t;

  // Write request from the loader to the image memories.
  typedef struct packed {
    logic               bm_we;
    logic               scr_we;
    logic               col_we;
    logic [BmAddrW-1:0] addr;
    logic [7:0]         data;
  } mbd_wr_t;

  // Read request from the pixel front end to the image memories.
  typedef struct packed {
    logic                 re;
    logic [BmAddrW-1:0]   bm_addr;
    logic [CellAddrW-1:0] cell_addr;
  } mbd_rd_t;

endpackage

// ----- rtl/core/multicolor_bitmap_pixel_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multicolor bitmap pixel decoder
// Loads a multicolor bitmap image byte by byte and answers pixel requests
// with palette RGB.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled: a
// load byte is written to the image memories in the cycle it is accepted
// and gives no result; a pixel request reads the bitmap, screen and color
// memories at once (one port each, registered read data) and its result
// lands in the output register after the request stage. The memories need
// no clearing after reset. Pixel requests made before all 10001 image bytes
// are taken return black with not_loaded set. A stalled output holds the
// request stage and then the input.
module multicolor_bitmap_pixel_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mbd_pkg::mbd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mbd_pkg::mbd_out_t out_data_o
);

  logic              in_take;
  logic              pix_take;
  logic              load_take;
  logic              advance;
  logic              loaded;
  logic [3:0]        background;
  logic [7:0]        col_c;
  logic [7:0]        row_c;
  logic [5:0]        cell_x;
  logic [4:0]        cell_y;
  mbd_pkg::mbd_wr_t  wr;
  mbd_pkg::mbd_rd_t  rd;
  logic [7:0]        bm_data;
  logic [7:0]        scr_data;
  logic [3:0]        col_data;
  mbd_pkg::mbd_out_t shade;

  logic              s1_valid_q;
  logic              s1_nl_q;
  logic [1:0]        s1_sub_q;
  logic              out_valid_q;
  mbd_pkg::mbd_out_t out_q;

  // Handshake and pipeline advance.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign pix_take   = in_take && (in_data_i.req_type == mbd_pkg::ReqPixel);
  assign load_take  = in_take && (in_data_i.req_type == mbd_pkg::ReqLoad);

  mbd_loader u_loader (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load_take),
    .byte_i       (in_data_i.load_byte),
    .wr_o         (wr),
    .background_o (background),
    .loaded_o     (loaded)
  );

  // Clamp coordinates and form memory addresses.
  assign col_c  = (in_data_i.column > mbd_pkg::LastColumn) ? mbd_pkg::LastColumn
                                                           : in_data_i.column;
  assign row_c  = (in_data_i.row > mbd_pkg::LastRow) ? mbd_pkg::LastRow : in_data_i.row;
  assign cell_x = col_c[7:2];
  assign cell_y = row_c[7:3];

  always_comb begin
    rd.re        = pix_take;
    // Cell row stride: 320 bitmap bytes, 40 screen cells.
    rd.bm_addr   = mbd_pkg::BmAddrW'({cell_y, 8'b0}) + mbd_pkg::BmAddrW'({cell_y, 6'b0}) +
                   mbd_pkg::BmAddrW'({cell_x, 3'b0}) + mbd_pkg::BmAddrW'(row_c[2:0]);
    rd.cell_addr = mbd_pkg::CellAddrW'({cell_y, 5'b0}) + mbd_pkg::CellAddrW'({cell_y, 3'b0}) +
                   mbd_pkg::CellAddrW'(cell_x);
  end

  mbd_store u_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_i       (rd),
    .bm_data_o  (bm_data),
    .scr_data_o (scr_data),
    .col_data_o (col_data)
  );

  // Request stage, aligned with the memory read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_nl_q    <= 1'b0;
      s1_sub_q   <= '0;
    end else if (advance || !s1_valid_q) begin
      s1_valid_q <= pix_take;
      if (pix_take) begin
        s1_nl_q  <= !loaded;
        s1_sub_q <= col_c[1:0];
      end
    end
  end

  mbd_shade u_shade (
    .not_loaded_i (s1_nl_q),
    .sub_i        (s1_sub_q),
    .bm_data_i    (bm_data),
    .scr_data_i   (scr_data),
    .col_data_i   (col_data),
    .background_i (background),
    .pix_o        (shade)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_q <= shade;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/mbd_loader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multicolor bitmap image loader
// Tracks the load position, drops a leading load address and turns each
// image byte into a write of the bitmap, screen or color memory or the
// background register.
// ----------------------------------------------------------------------------
module mbd_loader (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [7:0]        byte_i,
  output mbd_pkg::mbd_wr_t  wr_o,
  output logic [3:0]        background_o,
  output logic              loaded_o
);

  logic [mbd_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [7:0]                 held_q, held_d;
  logic                       hdr_q, hdr_d;
  logic [3:0]                 bg_q, bg_d;

  // Header check and byte placement.
  always_comb begin
    cnt_d  = cnt_q;
    held_d = held_q;
    hdr_d  = hdr_q;
    bg_d   = bg_q;
    wr_o   = '0;
    wr_o.data = byte_i;
    if (load_i) begin
      if (!hdr_q && cnt_q == mbd_pkg::CountW'(1) && held_q == mbd_pkg::HdrFirst &&
          byte_i == mbd_pkg::HdrSecond) begin
        hdr_d = 1'b1;
        cnt_d = '0;
      end else if (cnt_q < mbd_pkg::ImageBytes) begin
        if (cnt_q == '0 && !hdr_q) begin
          held_d = byte_i;
        end
        cnt_d = cnt_q + mbd_pkg::CountW'(1);
        if (cnt_q < mbd_pkg::BitmapEnd) begin
          wr_o.bm_we = 1'b1;
          wr_o.addr  = cnt_q[mbd_pkg::BmAddrW-1:0];
        end else if (cnt_q < mbd_pkg::ScreenEnd) begin
          wr_o.scr_we = 1'b1;
          wr_o.addr   = mbd_pkg::BmAddrW'(cnt_q - mbd_pkg::BitmapEnd);
        end else if (cnt_q < mbd_pkg::ColorEnd) begin
          wr_o.col_we = 1'b1;
          wr_o.addr   = mbd_pkg::BmAddrW'(cnt_q - mbd_pkg::ScreenEnd);
        end else begin
          bg_d = byte_i[3:0];
        end
      end
    end
  end

  // Load state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      held_q <= '0;
      hdr_q  <= 1'b0;
      bg_q   <= '0;
    end else begin
      cnt_q  <= cnt_d;
      held_q <= held_d;
      hdr_q  <= hdr_d;
      bg_q   <= bg_d;
    end
  end

  assign background_o = bg_q;
  assign loaded_o     = (cnt_q == mbd_pkg::ImageBytes);

endmodule

// ----- rtl/core/mbd_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multicolor bitmap image memories
// Single-port bitmap, screen and color memories with registered read data.
// ----------------------------------------------------------------------------
module mbd_store (
  input  logic             clk_i,
  input  mbd_pkg::mbd_wr_t wr_i,
  input  mbd_pkg::mbd_rd_t rd_i,
  output logic [7:0]       bm_data_o,
  output logic [7:0]       scr_data_o,
  output logic [3:0]       col_data_o
);

  logic [7:0] bm_mem  [mbd_pkg::BitmapBytes];
  logic [7:0] scr_mem [mbd_pkg::ScreenBytes];
  logic [3:0] col_mem [mbd_pkg::ColorBytes];

  logic [7:0] bm_data_q;
  logic [7:0] scr_data_q;
  logic [3:0] col_data_q;

  // Bitmap memory.
  always_ff @(posedge clk_i) begin
    if (wr_i.bm_we) begin
      bm_mem[wr_i.addr] <= wr_i.data;
    end else if (rd_i.re) begin
      bm_data_q <= bm_mem[rd_i.bm_addr];
    end
  end

  // Screen memory.
  always_ff @(posedge clk_i) begin
    if (wr_i.scr_we) begin
      scr_mem[wr_i.addr[mbd_pkg::CellAddrW-1:0]] <= wr_i.data;
    end else if (rd_i.re) begin
      scr_data_q <= scr_mem[rd_i.cell_addr];
    end
  end

  // Color memory keeps the low nibble only.
  always_ff @(posedge clk_i) begin
    if (wr_i.col_we) begin
      col_mem[wr_i.addr[mbd_pkg::CellAddrW-1:0]] <= wr_i.data[3:0];
    end else if (rd_i.re) begin
      col_data_q <= col_mem[rd_i.cell_addr];
    end
  end

  assign bm_data_o  = bm_data_q;
  assign scr_data_o = scr_data_q;
  assign col_data_o = col_data_q;

endmodule

// ----- rtl/core/mbd_shade.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multicolor bitmap pixel shading
// Extracts the 2-bit pixel code, picks the color nibble and looks it up in
// the palette.
// ----------------------------------------------------------------------------
module mbd_shade (
  input  logic              not_loaded_i,
  input  logic [1:0]        sub_i,
  input  logic [7:0]        bm_data_i,
  input  logic [7:0]        scr_data_i,
  input  logic [3:0]        col_data_i,
  input  logic [3:0]        background_i,
  output mbd_pkg::mbd_out_t pix_o
);

  logic [1:0]  code;
  logic [3:0]  nibble;
  logic [23:0] rgb;

  // The leftmost pixel of a byte sits in its top two bits.
  always_comb begin
    case (sub_i)
      2'd0:    code = bm_data_i[7:6];
      2'd1:    code = bm_data_i[5:4];
      2'd2:    code = bm_data_i[3:2];
      default: code = bm_data_i[1:0];
    endcase
  end

  // Color source selected by the pixel code.
  always_comb begin
    unique case (code)
      mbd_pkg::CodeBackground: nibble = background_i;
      mbd_pkg::CodeScreenHigh: nibble = scr_data_i[7:4];
      mbd_pkg::CodeScreenLow:  nibble = scr_data_i[3:0];
      mbd_pkg::CodeColor:      nibble = col_data_i;
      default:                 nibble = background_i;
    endcase
  end

  assign rgb = mbd_pkg::Palette[nibble];

  // An early request answers black with the flag set.
  always_comb begin
    if (not_loaded_i) begin
      pix_o = '0;
      pix_o.not_loaded = 1'b1;
    end else begin
      pix_o.red        = rgb[23:16];
      pix_o.green      = rgb[15:8];
      pix_o.blue       = rgb[7:0];
      pix_o.not_loaded = 1'b0;
    end
  end

endmodule
